// ===== src/tlvp_pkg.sv =====
// Package for the TLV/TV stream parser: result kinds, error codes and the result record.
// Used by tlvp_core and tlv_tv_stream_parser. No dependencies.
package tlvp_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [KIND_W-1:0] KIND_TV      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TLV_HDR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  error_code;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] payload_offset;
        logic              last_of_element;
        logic              end_of_packet;
    } result_t;

endpackage

// ===== src/tlvp_core.sv =====
// Parser state and per-byte step logic: phase, tag, counters and the result of one byte.
// Depends on tlvp_pkg.
module tlvp_core
    import tlvp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              start_of_packet,
    input  logic [WORD_W-1:0] total_length,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              res_valid,
    output result_t           res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG_HI,
        PH_TAG_LO,
        PH_WORD_HI,
        PH_WORD_LO,
        PH_PAYLOAD,
        PH_DROP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] tag_reg, tag_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic [WORD_W-1:0] pkt_left_reg, pkt_left_next;
    logic [WORD_W-1:0] pay_left_reg, pay_left_next;
    logic [WORD_W-1:0] pos_reg, pos_next;

    phase_t            ph;
    logic [WORD_W-1:0] pkt_left;
    logic [WORD_W-1:0] pay_left;
    logic [WORD_W-1:0] pos;
    logic [WORD_W-1:0] pkt_dec;
    logic [WORD_W-1:0] pay_dec;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] full_tag;
    logic              last;
    logic              el_done;

    always_comb
    begin
        ph       = phase_reg;
        pkt_left = pkt_left_reg;
        pay_left = pay_left_reg;
        pos      = pos_reg;
        if (start_of_packet)
        begin
            pkt_left = total_length;
            pay_left = '0;
            pos      = '0;
            ph       = (total_length == '0) ? PH_IDLE : PH_TAG_HI;
        end

        pkt_dec  = pkt_left - WORD_W'(1);
        pay_dec  = pay_left - WORD_W'(1);
        last     = (pkt_dec == '0);
        el_done  = (pay_dec == '0) || last;
        w        = {hold_reg, data_byte};
        full_tag = {hold_reg, data_byte};

        phase_next    = ph;
        tag_next      = tag_reg;
        hold_next     = hold_reg;
        pkt_left_next = pkt_left;
        pay_left_next = pay_left;
        pos_next      = pos;

        res_valid           = 1'b0;
        res.kind            = KIND_ERROR;
        res.error_code      = ERR_NONE;
        res.tag             = tag_reg;
        res.word            = '0;
        res.payload_byte    = '0;
        res.payload_offset  = '0;
        res.last_of_element = 1'b0;
        res.end_of_packet   = 1'b0;

        if (ph == PH_IDLE || pkt_left == '0)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            pkt_left_next = pkt_dec;
            unique case (ph)
                PH_TAG_HI:
                begin
                    hold_next = data_byte;
                    if (last)
                    begin
                        phase_next        = PH_IDLE;
                        res_valid         = 1'b1;
                        res.error_code    = ERR_TRUNCATED;
                        res.tag           = {data_byte, {BYTE_W{1'b0}}};
                        res.end_of_packet = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAG_LO;
                    end
                end
                PH_TAG_LO:
                begin
                    tag_next = full_tag;
                    if (last)
                    begin
                        phase_next        = PH_IDLE;
                        res_valid         = 1'b1;
                        res.error_code    = ERR_TRUNCATED;
                        res.tag           = full_tag;
                        res.end_of_packet = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WORD_HI;
                    end
                end
                PH_WORD_HI:
                begin
                    hold_next = data_byte;
                    if (last)
                    begin
                        phase_next        = PH_IDLE;
                        res_valid         = 1'b1;
                        res.error_code    = ERR_TRUNCATED;
                        res.end_of_packet = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WORD_LO;
                    end
                end
                PH_WORD_LO:
                begin
                    res_valid = 1'b1;
                    if (tag_reg[0])
                    begin
                        phase_next        = last ? PH_IDLE : PH_TAG_HI;
                        res.kind          = KIND_TV;
                        res.word          = w;
                        res.end_of_packet = last;
                    end
                    else if (w > pkt_dec)
                    begin
                        phase_next        = last ? PH_IDLE : PH_DROP;
                        res.error_code    = ERR_TOO_LONG;
                        res.word          = w;
                        res.end_of_packet = 1'b1;
                    end
                    else if (w == '0)
                    begin
                        phase_next        = last ? PH_IDLE : PH_TAG_HI;
                        res.kind          = KIND_TLV_HDR;
                        res.end_of_packet = last;
                    end
                    else
                    begin
                        pay_left_next = w;
                        pos_next      = '0;
                        phase_next    = PH_PAYLOAD;
                        res.kind      = KIND_TLV_HDR;
                        res.word      = w;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_left_next       = pay_dec;
                    pos_next            = pos + WORD_W'(1);
                    if (el_done)
                    begin
                        phase_next = last ? PH_IDLE : PH_TAG_HI;
                    end
                    res_valid           = 1'b1;
                    res.kind            = KIND_PAYLOAD;
                    res.payload_byte    = data_byte;
                    res.payload_offset  = pos;
                    res.last_of_element = el_done;
                    res.end_of_packet   = last;
                end
                PH_DROP:
                begin
                    if (last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tag_reg      <= '0;
            hold_reg     <= '0;
            pkt_left_reg <= '0;
            pay_left_reg <= '0;
            pos_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            hold_reg     <= hold_next;
            pkt_left_reg <= pkt_left_next;
            pay_left_reg <= pay_left_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

// ===== src/tlv_tv_stream_parser.sv =====
// TLV/TV stream parser: one packet byte per request in, at most one parse result per byte out.
// A result passes from s_* through the input register and then the output register to m_*.
// Throughput: one byte per cycle unless m_* stalls; the input register, the step logic
// in tlvp_core and the output register form a two-stage pipeline that advances on out_free.
// Reset: asynchronous, clears parser state to idle with all counters zero, empties both stages.
// Depends on tlvp_pkg and tlvp_core.
module tlv_tv_stream_parser
    import tlvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // total_length[15:0], data_byte[23:16]
    input  logic [0:0]  s_tuser,   // start_of_packet[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // error_code[1:0], tag[17:2], word[33:18],
                                   // payload_byte[41:34], payload_offset[57:42],
                                   // last_of_element[58], zero[63:59]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast    // end_of_packet
);

    logic              in_valid_reg;
    logic              in_sop_reg;
    logic [WORD_W-1:0] in_len_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              advance;
    logic              out_free;
    logic              res_valid;
    result_t           res;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    tlvp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .start_of_packet (in_sop_reg),
        .total_length    (in_len_reg),
        .data_byte       (in_byte_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sop_reg  <= s_tuser[0];
            in_len_reg  <= s_tdata[15:0];
            in_byte_reg <= s_tdata[23:16];
        end
        if (out_free && advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.end_of_packet;
    assign m_tdata  = {5'd0, out_reg.last_of_element, out_reg.payload_offset,
                       out_reg.payload_byte, out_reg.word, out_reg.tag,
                       out_reg.error_code};

`ifndef SYNTHESIS
    a_error_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast)
        else $error("error result does not close the packet");

    a_error_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[1:0] != ERR_NONE)))
        else $error("error code disagrees with result kind");

    a_last_element_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[58] |-> m_tuser == KIND_PAYLOAD)
        else $error("end of element flagged on a non-payload result");

    a_pipeline_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input request lost while output stalled");
`endif

endmodule
